// File: src/dvru_pkg.sv
// Shared types and constants for the distance vector route update block.
// No dependencies; every other file of the block uses this package.
package dvru_pkg;

    localparam int NODES  = 16;
    localparam int NODE_W = 4;
    localparam int HOP_W  = 5;
    localparam int COST_W = 17;

    localparam logic [COST_W-1:0] COST_INF = 17'd99999;
    localparam logic [HOP_W-1:0]  HOP_NONE = 5'd16;

    typedef enum logic [1:0] {
        CMD_ROUTE  = 2'd0,
        CMD_LINK   = 2'd1,
        CMD_ADVERT = 2'd2
    } t_command;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_PASS = 1'b1
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_route;
        logic load_link;
        logic load_adv;
        logic start;
        logic step;
    } t_dp_ctl;

    // datapath to controller
    typedef struct packed {
        logic can_step;
        logic at_end;
    } t_dp_stat;

endpackage

// File: src/dvru_if.sv
// Channel interfaces: command beats in, table entry beats out.
// Depends on dvru_pkg for field widths.
interface dvru_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic [dvru_pkg::NODE_W-1:0]   node;
    logic [dvru_pkg::HOP_W-1:0]    next_hop;
    logic [dvru_pkg::COST_W-1:0]   cost;
    logic [dvru_pkg::NODE_W-1:0]   sender;
    logic                          last;

    modport source (output valid, command, node, next_hop, cost, sender, last,
                    input ready);
    modport sink   (input valid, command, node, next_hop, cost, sender, last,
                    output ready);
endinterface

interface dvru_res_if;
    logic                          valid;
    logic                          ready;
    logic [dvru_pkg::NODE_W-1:0]   dest;
    logic                          entry_valid;
    logic [dvru_pkg::HOP_W-1:0]    route_hop;
    logic [dvru_pkg::COST_W-1:0]   route_cost;
    logic                          changed;
    logic                          last_result;

    modport source (output valid, dest, entry_valid, route_hop, route_cost, changed,
                    last_result, input ready);
    modport sink   (input valid, dest, entry_valid, route_hop, route_cost, changed,
                    last_result, output ready);
endinterface

// File: src/dvru_ctrl.sv
// Controller: decodes command beats and sequences the update pass.
// Depends on dvru_pkg; drives the datapath through t_dp_ctl.
module dvru_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_command,
    input  logic               i_last,
    output logic               o_ready,
    input  dvru_pkg::t_dp_stat i_stat,
    output dvru_pkg::t_dp_ctl  o_ctl
);
    import dvru_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    case (i_command)
                        CMD_ROUTE:  o_ctl.load_route = 1'b1;
                        CMD_LINK:   o_ctl.load_link  = 1'b1;
                        CMD_ADVERT: begin
                            o_ctl.load_adv = 1'b1;
                            if (i_last) begin
                                o_ctl.start = 1'b1;
                                n_state     = S_PASS;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PASS: begin
                // advance one destination whenever the output register frees up
                if (i_stat.can_step) begin
                    o_ctl.step = 1'b1;
                    if (i_stat.at_end) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: src/dvru_dp.sv
// Datapath: route, link and advert tables, the add-compare update unit and
// the output register. Depends on dvru_pkg and dvru_res_if; driven by dvru_ctrl.
module dvru_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [dvru_pkg::NODE_W-1:0] i_cfg_wdata,
    input  logic [dvru_pkg::NODE_W-1:0] i_node,
    input  logic [dvru_pkg::HOP_W-1:0]  i_next_hop,
    input  logic [dvru_pkg::COST_W-1:0] i_cost,
    input  logic [dvru_pkg::NODE_W-1:0] i_sender,
    input  dvru_pkg::t_dp_ctl           i_ctl,
    output dvru_pkg::t_dp_stat          o_stat,
    dvru_res_if.source                  o_res
);
    import dvru_pkg::*;

    function automatic logic [COST_W-1:0] sat_cost(input logic [COST_W:0] c);
        sat_cost = (c > {1'b0, COST_INF}) ? COST_INF : c[COST_W-1:0];
    endfunction

    function automatic logic [HOP_W-1:0] fix_hop(input logic [HOP_W-1:0] h);
        fix_hop = (h >= HOP_NONE) ? HOP_NONE : h;
    endfunction

    logic              r_rvalid  [NODES];
    logic [HOP_W-1:0]  r_rnext   [NODES];
    logic [COST_W-1:0] r_rmetric [NODES];
    logic [COST_W-1:0] r_lcost   [NODES];
    logic [NODES-1:0]  r_adv_present;
    logic [COST_W-1:0] r_adv_metric [NODES];
    logic [HOP_W-1:0]  r_adv_next   [NODES];

    logic [NODE_W-1:0] r_own_id;
    logic [NODE_W-1:0] r_sender;
    logic [COST_W-1:0] r_link;
    logic [NODE_W-1:0] r_dest;

    logic              r_out_valid;
    logic              r_out_entry_valid;
    logic [NODE_W-1:0] r_out_dest;
    logic [HOP_W-1:0]  r_out_hop;
    logic [COST_W-1:0] r_out_cost;
    logic              r_out_changed;
    logic              r_out_last;
    logic              n_out_valid;

    logic [COST_W-1:0] adv;
    logic [HOP_W-1:0]  split;
    logic [COST_W-1:0] sum;
    logic [HOP_W-1:0]  snd_hop;
    logic              take;
    logic [HOP_W-1:0]  n_next;
    logic [COST_W-1:0] n_metric;

    assign snd_hop = {1'b0, r_sender};

    // update unit for the destination under r_dest
    always_comb begin
        if (r_dest == r_sender) begin
            adv   = '0;
            split = snd_hop;
        end else if (r_adv_present[r_dest]) begin
            adv   = r_adv_metric[r_dest];
            split = r_adv_next[r_dest];
        end else begin
            adv   = COST_INF;
            split = HOP_NONE;
        end
        sum  = sat_cost({1'b0, r_link} + {1'b0, adv});
        take = r_rvalid[r_dest] &&
               ((sum <= r_rmetric[r_dest]) ||
                (r_rnext[r_dest] == snd_hop && split != {1'b0, r_own_id}));
        n_next   = take ? snd_hop : r_rnext[r_dest];
        n_metric = take ? sum : r_rmetric[r_dest];
    end

    assign o_stat.can_step = !r_out_valid || o_res.ready;
    assign o_stat.at_end   = (r_dest == NODE_W'(NODES - 1));

    assign n_out_valid = i_ctl.step ? 1'b1 : (o_res.ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NODES; i++) begin
                r_rvalid[i]  <= 1'b0;
                r_rnext[i]   <= HOP_NONE;
                r_rmetric[i] <= COST_INF;
                r_lcost[i]   <= COST_INF;
            end
            r_adv_present <= '0;
            r_own_id      <= '0;
            r_out_valid   <= 1'b0;
            r_dest        <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_own_id <= i_cfg_wdata;
            end
            if (i_ctl.load_route) begin
                r_rvalid[i_node]  <= 1'b1;
                r_rnext[i_node]   <= fix_hop(i_next_hop);
                r_rmetric[i_node] <= sat_cost({1'b0, i_cost});
            end
            if (i_ctl.load_link) begin
                r_lcost[i_node] <= sat_cost({1'b0, i_cost});
            end
            if (i_ctl.load_adv) begin
                r_adv_present[i_node] <= 1'b1;
            end
            if (i_ctl.start) begin
                r_dest <= '0;
            end
            if (i_ctl.step) begin
                r_rnext[r_dest]   <= n_next;
                r_rmetric[r_dest] <= n_metric;
                r_dest            <= r_dest + NODE_W'(1);
                if (o_stat.at_end) begin
                    r_adv_present <= '0;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_adv) begin
            r_adv_metric[i_node] <= sat_cost({1'b0, i_cost});
            r_adv_next[i_node]   <= fix_hop(i_next_hop);
        end
        if (i_ctl.start) begin
            r_sender <= i_sender;
            r_link   <= r_lcost[i_sender];
        end
        if (i_ctl.step) begin
            r_out_dest        <= r_dest;
            r_out_entry_valid <= r_rvalid[r_dest];
            r_out_hop         <= n_next;
            r_out_cost        <= n_metric;
            r_out_changed     <= take;
            r_out_last        <= o_stat.at_end;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.dest        = r_out_dest;
    assign o_res.entry_valid = r_out_entry_valid;
    assign o_res.route_hop   = r_out_hop;
    assign o_res.route_cost  = r_out_cost;
    assign o_res.changed     = r_out_changed;
    assign o_res.last_result = r_out_last;

`ifndef ASSERT_OFF
    a_step_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.step |-> (!r_out_valid || o_res.ready))
        else $error("pass step overwrote an untaken result");

    a_adv_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.step && o_stat.at_end) |=> (r_adv_present == '0))
        else $error("advert buffer not cleared after pass");

    a_changed_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out_changed || r_out_entry_valid))
        else $error("invalid entry reported as changed");

    a_cost_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_cost <= COST_INF))
        else $error("route cost above unreachable");
`endif

endmodule

// File: src/distance_vector_route_update.sv
// Top level of the distance vector route update block.
// Depends on dvru_pkg, dvru_if, dvru_ctrl and dvru_dp.
//
// Usage:
//   i_cmd carries command beats: load a route, set a neighbour link cost,
//   or buffer an advertised entry. Each beat is taken while the block is
//   idle; command code 3 is dropped.
//   An advert beat with last set starts an update pass: the block walks
//   every destination in order, one per cycle while the receiver does not
//   stall, through a single shared add/saturate/compare unit, and emits
//   one table entry beat on o_res per destination. A pass is 16 result
//   beats; the first is offered once the controller is in S_PASS and its
//   first step has loaded the output register. i_cmd.ready stays low
//   during the pass and rises again once the final entry sits in the
//   output register, so the next command may enter while it waits.
//   A receiver stall freezes the walk; the output register holds its beat.
//   i_cfg_we / i_cfg_wdata write this node's id; write only while idle.
//   Reset (synchronous, active low) clears the route and link tables and
//   the advert present flags, not the advert payload: no clearing sweep, the block is ready the cycle after reset.
module distance_vector_route_update (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [dvru_pkg::NODE_W-1:0] i_cfg_wdata,
    dvru_cmd_if.sink                    i_cmd,
    dvru_res_if.source                  o_res
);
    import dvru_pkg::*;

    t_dp_ctl  ctl;
    t_dp_stat stat;
    logic     ready;

    assign i_cmd.ready = ready;

    // controller: decode beats, run the pass
    dvru_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_cmd.valid),
        .i_command (i_cmd.command),
        .i_last    (i_cmd.last),
        .o_ready   (ready),
        .i_stat    (stat),
        .o_ctl     (ctl)
    );

    // datapath: tables, update unit, output register
    dvru_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_node      (i_cmd.node),
        .i_next_hop  (i_cmd.next_hop),
        .i_cost      (i_cmd.cost),
        .i_sender    (i_cmd.sender),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .o_res       (o_res)
    );

endmodule
